>>> hdl/lcm_pkg.sv
// ----------------------------------------------------------------------------
// lcm_pkg: shared types and constants of the lockstep checksum matcher
// Slot depth, slot index type, and the per-side store control bundle.
// ----------------------------------------------------------------------------
`default_nettype none

package lcm_pkg;

  // Slots per side; a power of two, so the slot is the low tick bits
  localparam int unsigned DEPTH  = 16;
  localparam int unsigned SLOT_W = $clog2(DEPTH);

  localparam int unsigned TICK_W = 32;
  localparam int unsigned SUM_W  = 32;

  typedef logic [SLOT_W-1:0] slot_t;
  typedef logic [TICK_W-1:0] tick_t;
  typedef logic [SUM_W-1:0]  sum_t;

  // Source side of a checksum
  typedef enum logic {
    SIDE_LOCAL  = 1'b0,
    SIDE_REMOTE = 1'b1
  } side_t;

  // Update request to one side's store
  typedef struct packed {
    logic  wr;    // write tick and value, mark present
    logic  clr;   // clear present mark (wins over wr)
    slot_t idx;
  } store_ctrl_t;

  // Contents of one slot as seen at the current index
  typedef struct packed {
    logic  present;
    tick_t tick;
    sum_t  value;
  } slot_rd_t;

endpackage

`default_nettype wire

>>> hdl/lcm_side_store.sv
// ----------------------------------------------------------------------------
// lcm_side_store: checksum slots of one side
// Register-held tick and value per slot, present marks cleared by reset.
// ----------------------------------------------------------------------------
`default_nettype none

module lcm_side_store (
  input  wire                  clk,
  input  wire                  rst,
  input  lcm_pkg::store_ctrl_t ctrl,
  input  lcm_pkg::slot_t       rd_idx,
  input  lcm_pkg::tick_t       wr_tick,
  input  lcm_pkg::sum_t        wr_value,
  output lcm_pkg::slot_rd_t    rd
);

  lcm_pkg::tick_t            tick_mem  [lcm_pkg::DEPTH];
  lcm_pkg::sum_t             value_mem [lcm_pkg::DEPTH];
  logic [lcm_pkg::DEPTH-1:0] present;

  // Write tick and value of the addressed slot
  always_ff @(posedge clk) begin
    if (ctrl.wr) begin
      tick_mem[ctrl.idx]  <= wr_tick;
      value_mem[ctrl.idx] <= wr_value;
    end
  end

  // Set or drop the present mark; a clear wins
  always_ff @(posedge clk) begin
    if (rst) begin
      present <= '0;
    end else if (ctrl.clr) begin
      present[ctrl.idx] <= 1'b0;
    end else if (ctrl.wr) begin
      present[ctrl.idx] <= 1'b1;
    end
  end

  // Read the slot under the current item
  always_comb begin
    rd.present = present[rd_idx];
    rd.tick    = tick_mem[rd_idx];
    rd.value   = value_mem[rd_idx];
  end

endmodule

`default_nettype wire

>>> hdl/lcm_match.sv
// ----------------------------------------------------------------------------
// lcm_match: compare stage and result register
// Checks the other side's slot, drives store updates, holds the sticky flag.
// ----------------------------------------------------------------------------
`default_nettype none

module lcm_match (
  input  wire                   clk,
  input  wire                   rst,
  input  wire                   item_valid,
  input  lcm_pkg::side_t        side,
  input  lcm_pkg::tick_t        tick,
  input  lcm_pkg::sum_t         checksum,
  input  lcm_pkg::slot_rd_t     local_rd,
  input  lcm_pkg::slot_rd_t     remote_rd,
  output lcm_pkg::store_ctrl_t  local_ctrl,
  output lcm_pkg::store_ctrl_t  remote_ctrl,
  output logic                  advance,
  output logic                  out_valid,
  input  wire                   out_ready,
  output logic                  compared,
  output logic                  mismatch,
  output logic                  out_of_sync
);

  lcm_pkg::slot_rd_t other;
  lcm_pkg::slot_t    idx;
  logic              hit;
  logic              diff;
  logic              desync;

  assign idx     = tick[lcm_pkg::SLOT_W-1:0];
  assign advance = item_valid && (!out_valid || out_ready);

  // Pick the opposite side and check for a same-tick pair
  always_comb begin
    unique case (side)
      lcm_pkg::SIDE_LOCAL:  other = remote_rd;
      lcm_pkg::SIDE_REMOTE: other = local_rd;
      default:              other = remote_rd;
    endcase
    hit  = other.present && (other.tick == tick);
    diff = other.value != checksum;
  end

  // Write this side's slot; clear both marks after a comparison
  always_comb begin
    local_ctrl.idx  = idx;
    remote_ctrl.idx = idx;
    local_ctrl.wr   = advance && (side == lcm_pkg::SIDE_LOCAL);
    remote_ctrl.wr  = advance && (side == lcm_pkg::SIDE_REMOTE);
    local_ctrl.clr  = advance && hit;
    remote_ctrl.clr = advance && hit;
  end

  // Hold the sticky out-of-sync state
  always_ff @(posedge clk) begin
    if (rst) begin
      desync <= 1'b0;
    end else if (advance && hit && diff) begin
      desync <= 1'b1;
    end
  end

  // Result valid: load on advance, drop on transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (rst) begin
      compared    <= 1'b0;
      mismatch    <= 1'b0;
      out_of_sync <= 1'b0;
    end else if (advance) begin
      compared    <= hit;
      mismatch    <= hit && diff;
      out_of_sync <= desync || (hit && diff);
    end
  end

endmodule

`default_nettype wire

>>> hdl/lockstep_checksum_matcher_top.sv
// ----------------------------------------------------------------------------
// lockstep_checksum_matcher_top: match lockstep peer checksums by tick
// Stores local and remote checksums by tick slot, compares same-tick pairs.
// ----------------------------------------------------------------------------
//  channel | handshake            | payload
//  --------+----------------------+----------------------------------
//  in      | in_valid / in_ready  | op, tick, checksum
//  out     | out_valid / out_ready| compared, mismatch, out_of_sync
//
//  One item per cycle sustained while out_ready is high; the result passes
//  through the input register and then the result register.
//  The input register feeds one slot read, compare and write into the
//  register-held slots, so each item sees all earlier updates.
//  Reset clears the present marks, the sticky flag and both valid bits.
//  A stalled output holds the result; one more item waits in the input
//  register before in_ready drops.
// ----------------------------------------------------------------------------
`default_nettype none

module lockstep_checksum_matcher_top (
  input  wire                       clk,
  input  wire                       rst,
  input  wire                       in_valid,
  output logic                      in_ready,
  input  wire                       op,
  input  wire [lcm_pkg::TICK_W-1:0] tick,
  input  wire [lcm_pkg::SUM_W-1:0]  checksum,
  output logic                      out_valid,
  input  wire                       out_ready,
  output logic                      compared,
  output logic                      mismatch,
  output logic                      out_of_sync
);

  logic                 in_q_valid;
  lcm_pkg::side_t       side_q;
  lcm_pkg::tick_t       tick_q;
  lcm_pkg::sum_t        checksum_q;
  logic                 advance;
  lcm_pkg::store_ctrl_t local_ctrl;
  lcm_pkg::store_ctrl_t remote_ctrl;
  lcm_pkg::slot_rd_t    local_rd;
  lcm_pkg::slot_rd_t    remote_rd;

  assign in_ready = !in_q_valid || advance;

  // Input register valid
  always_ff @(posedge clk) begin
    if (rst) begin
      in_q_valid <= 1'b0;
    end else if (in_ready) begin
      in_q_valid <= in_valid;
    end
  end

  // Input register payload
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      side_q     <= lcm_pkg::side_t'(op);
      tick_q     <= tick;
      checksum_q <= checksum;
    end
  end

  lcm_side_store u_local (
    .clk      (clk),
    .rst      (rst),
    .ctrl     (local_ctrl),
    .rd_idx   (tick_q[lcm_pkg::SLOT_W-1:0]),
    .wr_tick  (tick_q),
    .wr_value (checksum_q),
    .rd       (local_rd)
  );

  lcm_side_store u_remote (
    .clk      (clk),
    .rst      (rst),
    .ctrl     (remote_ctrl),
    .rd_idx   (tick_q[lcm_pkg::SLOT_W-1:0]),
    .wr_tick  (tick_q),
    .wr_value (checksum_q),
    .rd       (remote_rd)
  );

  lcm_match u_match (
    .clk         (clk),
    .rst         (rst),
    .item_valid  (in_q_valid),
    .side        (side_q),
    .tick        (tick_q),
    .checksum    (checksum_q),
    .local_rd    (local_rd),
    .remote_rd   (remote_rd),
    .local_ctrl  (local_ctrl),
    .remote_ctrl (remote_ctrl),
    .advance     (advance),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .compared    (compared),
    .mismatch    (mismatch),
    .out_of_sync (out_of_sync)
  );

  // A mismatch only comes from a comparison and always sets the flag
  a_mismatch_compared: assert property (@(posedge clk) disable iff (rst)
    out_valid && mismatch |-> compared && out_of_sync)
    else $error("mismatch without comparison or flag");

  // The out-of-sync flag never falls outside reset
  a_flag_sticky: assert property (@(posedge clk) disable iff (rst)
    out_of_sync |=> out_of_sync)
    else $error("out_of_sync dropped");

  // A held input item stays until it moves to the result stage
  a_input_held: assert property (@(posedge clk) disable iff (rst)
    in_q_valid && !advance |=> in_q_valid && $stable(tick_q))
    else $error("input item lost while stalled");

  // Both sides never update the same slot contents in one cycle
  a_one_writer: assert property (@(posedge clk) disable iff (rst)
    !(local_ctrl.wr && remote_ctrl.wr))
    else $error("both stores written by one item");

endmodule

`default_nettype wire

>>> test/lockstep_checksum_matcher_top_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lockstep_checksum_matcher_top_test: self-checking bench for the matcher
// Walks a directed table of pairing cases, then random lockstep windows of
// local/remote checksums mixed with noise. Each result is scored against a
// local slot-store predictor or a hand-typed expectation, with random idling
// on both sides and one long output hold-off that backs up the input.

module lockstep_checksum_matcher_top_test;

  // Result of one transfer: compared, mismatch, out_of_sync
  typedef struct packed {
    logic compared;
    logic mismatch;
    logic out_of_sync;
  } verdict_t;

  // One checksum transfer, with an optional hand-typed expectation
  typedef struct packed {
    lcm_pkg::side_t side;
    lcm_pkg::tick_t tick;
    lcm_pkg::sum_t  sum;
    logic           typed;
    verdict_t       want;
  } beat_t;

  localparam verdict_t HELD          = 3'b000;
  localparam verdict_t PAIRED        = 3'b100;
  localparam verdict_t SPLIT         = 3'b111;
  localparam verdict_t HELD_DESYNC   = 3'b001;
  localparam verdict_t PAIRED_DESYNC = 3'b101;

  localparam int RANDOM_BEATS = 1030;
  localparam int HOLD_AT      = 520;
  localparam int HOLD_CYCLES  = 80;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int DIRECTED_N   = 23;

  // Directed cases: pairing, extremes, overwrite, repeat side, desync
  localparam beat_t DIRECTED_ROWS [DIRECTED_N] = '{
    '{lcm_pkg::SIDE_LOCAL,  32'h0000_0000, 32'h0000_0000, 1'b1, HELD},
    '{lcm_pkg::SIDE_REMOTE, 32'h0000_0000, 32'h0000_0000, 1'b1, PAIRED},
    '{lcm_pkg::SIDE_LOCAL,  32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, HELD},
    '{lcm_pkg::SIDE_REMOTE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, PAIRED},
    '{lcm_pkg::SIDE_REMOTE, 32'h0000_0005, 32'h1234_5678, 1'b1, HELD},
    '{lcm_pkg::SIDE_LOCAL,  32'h0000_0015, 32'h1234_5678, 1'b1, HELD},
    '{lcm_pkg::SIDE_LOCAL,  32'h0000_0005, 32'h1234_5678, 1'b1, PAIRED},
    '{lcm_pkg::SIDE_REMOTE, 32'h0000_0025, 32'hAAAA_5555, 1'b1, HELD},
    '{lcm_pkg::SIDE_REMOTE, 32'h0000_0025, 32'h5555_AAAA, 1'b1, HELD},
    '{lcm_pkg::SIDE_LOCAL,  32'h0000_0025, 32'h5555_AAAA, 1'b1, PAIRED},
    '{lcm_pkg::SIDE_LOCAL,  32'h0000_0009, 32'h0000_0001, 1'b1, HELD},
    '{lcm_pkg::SIDE_LOCAL,  32'h0000_0019, 32'h0000_0002, 1'b0, HELD},
    '{lcm_pkg::SIDE_REMOTE, 32'h0000_0009, 32'h0000_0001, 1'b0, HELD},
    '{lcm_pkg::SIDE_REMOTE, 32'h0000_0019, 32'h0000_0002, 1'b0, HELD},
    '{lcm_pkg::SIDE_LOCAL,  32'h8000_0003, 32'h0000_0000, 1'b1, HELD},
    '{lcm_pkg::SIDE_REMOTE, 32'h8000_0003, 32'h0000_0000, 1'b1, PAIRED},
    '{lcm_pkg::SIDE_LOCAL,  32'h0000_0003, 32'h0000_0000, 1'b1, HELD},
    '{lcm_pkg::SIDE_REMOTE, 32'h7FFF_FFF3, 32'h0000_0000, 1'b1, HELD},
    '{lcm_pkg::SIDE_LOCAL,  32'h7FFF_FFF3, 32'hFFFF_FFFF, 1'b1, SPLIT},
    '{lcm_pkg::SIDE_REMOTE, 32'h0000_000C, 32'hCAFE_F00D, 1'b1, HELD_DESYNC},
    '{lcm_pkg::SIDE_LOCAL,  32'h0000_000C, 32'hCAFE_F00D, 1'b1, PAIRED_DESYNC},
    '{lcm_pkg::SIDE_LOCAL,  32'h0000_000C, 32'h0000_0000, 1'b1, HELD_DESYNC},
    '{lcm_pkg::SIDE_LOCAL,  32'h0000_000C, 32'h0000_0001, 1'b0, HELD}
  };

  logic           clk;
  logic           rst;
  logic           in_valid;
  logic           in_ready;
  logic           op;
  lcm_pkg::tick_t tick;
  lcm_pkg::sum_t  checksum;
  logic           out_valid;
  logic           out_ready;
  logic           compared;
  logic           mismatch;
  logic           out_of_sync;

  // Predictor copy of both slot stores and the sticky flag
  lcm_pkg::tick_t held_tick [2][lcm_pkg::DEPTH];
  lcm_pkg::sum_t  held_sum  [2][lcm_pkg::DEPTH];
  bit             held_full [2][lcm_pkg::DEPTH];
  bit             desync_seen;

  beat_t    feed_q [$];
  verdict_t verdict_q [$];
  int       n_accepted;
  int       total_beats;
  int       n_errors;
  int       cycle_count;
  bit       hold_active;

  lockstep_checksum_matcher_top uut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .op          (op),
    .tick        (tick),
    .checksum    (checksum),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .compared    (compared),
    .mismatch    (mismatch),
    .out_of_sync (out_of_sync)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  task automatic report_error(input string msg);
    $display("ERROR @%0t: %s", $time, msg);
    n_errors++;
  endtask

  // Store the checksum in its side's slot, then pair it if both sides hold this tick
  function automatic verdict_t match_checksum(lcm_pkg::side_t src, lcm_pkg::tick_t t,
                                              lcm_pkg::sum_t v);
    int unsigned idx;
    int          s;
    verdict_t    res;
    idx = t % lcm_pkg::DEPTH;
    s   = (src == lcm_pkg::SIDE_REMOTE) ? 1 : 0;
    res = HELD;
    held_tick[s][idx] = t;
    held_sum[s][idx]  = v;
    held_full[s][idx] = 1'b1;
    if (held_full[0][idx] && held_full[1][idx] &&
        held_tick[0][idx] == t && held_tick[1][idx] == t) begin
      res.compared = 1'b1;
      res.mismatch = (held_sum[0][idx] != held_sum[1][idx]);
      if (res.mismatch) desync_seen = 1'b1;
      held_full[0][idx] = 1'b0;
      held_full[1][idx] = 1'b0;
    end
    res.out_of_sync = desync_seen;
    return res;
  endfunction

  // Idle both sides except during the quiet stretch, the hold-off and the tail
  function automatic bit idling_on();
    return !hold_active && !(n_accepted >= 300 && n_accepted < 420) &&
           (n_accepted + 150 < total_beats);
  endfunction

  // Queue a window of consecutive ticks from both peers in shuffled order
  task automatic add_lockstep_window();
    beat_t          grp [$];
    beat_t          tmp;
    lcm_pkg::tick_t base;
    lcm_pkg::sum_t  s;
    lcm_pkg::sum_t  r;
    int             n;
    int             j;
    base = $urandom;
    if ($urandom_range(0, 7) == 0)
      base = 32'hFFFF_FFFF - $urandom_range(0, lcm_pkg::DEPTH);
    n = $urandom_range(1, lcm_pkg::DEPTH);
    for (int i = 0; i < n; i++) begin
      s = $urandom;
      r = ($urandom_range(0, 15) == 0) ? (s ^ (32'h1 << $urandom_range(0, 31))) : s;
      grp.push_back('{lcm_pkg::SIDE_LOCAL, lcm_pkg::tick_t'(base + i), s, 1'b0, HELD});
      grp.push_back('{lcm_pkg::SIDE_REMOTE, lcm_pkg::tick_t'(base + i), r, 1'b0, HELD});
      // occasionally resend one side for the same tick
      if ($urandom_range(0, 9) == 0)
        grp.push_back('{lcm_pkg::side_t'($urandom_range(0, 1)),
                        lcm_pkg::tick_t'(base + i), lcm_pkg::sum_t'($urandom),
                        1'b0, HELD});
    end
    for (int k = grp.size() - 1; k > 0; k--) begin
      j      = $urandom_range(0, k);
      tmp    = grp[k];
      grp[k] = grp[j];
      grp[j] = tmp;
    end
    foreach (grp[k]) feed_q.push_back(grp[k]);
  endtask

  // Queue one to eight unrelated checksums, about half on low ticks so slots collide
  task automatic add_noise();
    lcm_pkg::tick_t t;
    int             n;
    n = $urandom_range(1, 8);
    repeat (n) begin
      t = $urandom_range(0, 1) ? lcm_pkg::tick_t'($urandom)
                               : lcm_pkg::tick_t'($urandom_range(0, 47));
      feed_q.push_back('{lcm_pkg::side_t'($urandom_range(0, 1)), t,
                         lcm_pkg::sum_t'($urandom), 1'b0, HELD});
    end
  endtask

  // Score output transfers, then predict accepted input transfers
  always @(posedge clk) begin : scoreboard
    verdict_t got;
    verdict_t want;
    beat_t    cur;
    if (!rst) begin
      if (out_valid && out_ready) begin
        got = {compared, mismatch, out_of_sync};
        if (verdict_q.size() == 0) begin
          report_error("result transfer with no expectation pending");
        end else begin
          want = verdict_q.pop_front();
          if (got.compared !== want.compared)
            report_error($sformatf("compared got %b want %b", got.compared, want.compared));
          if (got.mismatch !== want.mismatch)
            report_error($sformatf("mismatch got %b want %b", got.mismatch, want.mismatch));
          if (got.out_of_sync !== want.out_of_sync)
            report_error($sformatf("out_of_sync got %b want %b",
                                   got.out_of_sync, want.out_of_sync));
        end
      end
      if (in_valid && in_ready) begin
        cur  = feed_q[n_accepted];
        want = match_checksum(lcm_pkg::side_t'(op), tick, checksum);
        if (cur.typed) want = cur.want;
        verdict_q.push_back(want);
        n_accepted++;
      end
    end
  end

  // End the run if it stalls
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("lockstep_checksum_matcher_top test failed");
      $finish;
    end
  end

  // Result side: random stalls, plus one long hold-off to back up the input
  initial begin : drain
    int stall;
    bit hold_done;
    hold_done = 1'b0;
    out_ready = 1'b0;
    while (rst !== 1'b0) @(negedge clk);
    forever begin
      @(negedge clk);
      if (!hold_done && n_accepted >= HOLD_AT) begin
        hold_active = 1'b1;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
        hold_active = 1'b0;
        hold_done   = 1'b1;
      end else if (idling_on() && $urandom_range(0, 3) == 0) begin
        stall = $urandom_range(1, 15);
        out_ready <= 1'b0;
        repeat (stall - 1) @(negedge clk);
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Reset, build the stimulus, drive it, then wait for the last results
  initial begin : feed
    int gap;
    rst         = 1'b1;
    in_valid    = 1'b0;
    op          = 1'b0;
    tick        = '0;
    checksum    = '0;
    desync_seen = 1'b0;
    hold_active = 1'b0;
    n_accepted  = 0;
    n_errors    = 0;
    cycle_count = 0;

    foreach (DIRECTED_ROWS[k]) feed_q.push_back(DIRECTED_ROWS[k]);
    while (feed_q.size() < DIRECTED_N + RANDOM_BEATS) begin
      if ($urandom_range(0, 3) != 0) add_lockstep_window();
      else add_noise();
    end
    total_beats = feed_q.size();

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (feed_q[k]) begin
      // idle the input for a burst before this transfer
      if (idling_on() && $urandom_range(0, 3) == 0) begin
        gap = $urandom_range(1, 15);
        @(negedge clk);
        in_valid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
      @(negedge clk);
      in_valid <= 1'b1;
      op       <= feed_q[k].side;
      tick     <= feed_q[k].tick;
      checksum <= feed_q[k].sum;
      @(posedge clk);
      while (!in_ready) @(posedge clk);
    end
    @(negedge clk);
    in_valid <= 1'b0;

    while (verdict_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (n_errors == 0)
      $display("lockstep_checksum_matcher_top test passed");
    else
      $display("lockstep_checksum_matcher_top test failed");
    $finish;
  end

endmodule
